### sv/ttd_pkg.sv
package ttd_pkg;

  localparam int unsigned ANGLE_W    = 9;
  localparam int unsigned ANG_W      = 8;
  localparam int unsigned CELL_W     = 8;
  localparam int unsigned PWM_W      = 10;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned TPD_W      = 40;
  localparam int unsigned TPD_FRAC   = 8;
  localparam int unsigned TICK_W     = 40;
  localparam int unsigned DRIVE_W    = 40;
  localparam int unsigned PROD_W     = ANG_W + TPD_W;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 40;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned OUT_DEPTH   = 2;
  localparam int unsigned OUT_PTR_W   = $clog2(OUT_DEPTH);
  localparam int unsigned OUT_CNT_W   = $clog2(OUT_DEPTH + 1);

  localparam logic [ANGLE_W-1:0] DEG_FULL   = 9'd360;
  localparam logic [ANGLE_W-1:0] QUARTER_LO = 9'd89;
  localparam logic [ANGLE_W-1:0] QUARTER_HI = 9'd91;
  localparam logic [ANGLE_W-1:0] HALF_LO    = 9'd179;
  localparam logic [ANGLE_W-1:0] HALF_HI    = 9'd181;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_MOVE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RIGHT_PWM_ON,
    REG_LEFT_PWM_ON,
    REG_LEFT_QUARTER,
    REG_RIGHT_QUARTER,
    REG_HALF_TURN,
    REG_TICKS_PER_DEG,
    REG_PAUSE,
    REG_TICKS_PER_CELL
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_TURN,
    PH_PAUSE,
    PH_DRIVE
  } phase_e;

  typedef enum logic [1:0] {
    TC_QUARTER,
    TC_HALF,
    TC_SCALED
  } turn_cls_e;

  typedef struct packed {
    logic               cmd;
    logic [ANGLE_W-1:0] pose_angle;
    logic [ANGLE_W-1:0] target_heading;
    logic [CELL_W-1:0]  cell_count;
  } in_item_t;

  typedef struct packed {
    logic [PWM_W-1:0]   pwm_right;
    logic [PWM_W-1:0]   pwm_left;
    logic               drive_forward;
    logic [1:0]         phase;
    logic [ANGLE_W-1:0] ccw_angle;
    logic               rejected;
    logic               finished;
  } result_t;

  typedef struct packed {
    logic [PWM_W-1:0] right_pwm_on;
    logic [PWM_W-1:0] left_pwm_on;
    logic [CNT_W-1:0] left_quarter_ticks;
    logic [CNT_W-1:0] right_quarter_ticks;
    logic [CNT_W-1:0] half_turn_ticks;
    logic [TPD_W-1:0] ticks_per_degree;
    logic [CNT_W-1:0] pause_ticks;
    logic [CNT_W-1:0] ticks_per_cell;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    right_pwm_on:        10'd512,
    left_pwm_on:         10'd512,
    left_quarter_ticks:  32'd0,
    right_quarter_ticks: 32'd0,
    half_turn_ticks:     32'd0,
    ticks_per_degree:    40'd0,
    pause_ticks:         32'd112500000,
    ticks_per_cell:      32'd0
  };

  typedef struct packed {
    logic               cmd;
    logic               zero;
    logic               left;
    turn_cls_e          cls;
    logic [ANGLE_W-1:0] ccw;
    logic [ANG_W-1:0]   ang;
    logic [CELL_W-1:0]  cells;
  } front_t;

  typedef struct packed {
    logic               cmd;
    logic               zero;
    logic               left;
    logic [ANGLE_W-1:0] ccw;
    logic [TICK_W-1:0]  turn_ticks;
    logic [DRIVE_W-1:0] drive_ticks;
  } dec_t;

  typedef struct packed {
    logic ready;
    logic valid;
  } q_status_t;

endpackage

### sv/ttd_cfg.sv
module ttd_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ttd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ttd_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  output ttd_pkg::cfg_t                    cfg_o
);

  ttd_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (ttd_pkg::cfg_reg_e'(cfg_idx_i))
        ttd_pkg::REG_RIGHT_PWM_ON:   cfg_d.right_pwm_on = cfg_wdata_i[ttd_pkg::PWM_W-1:0];
        ttd_pkg::REG_LEFT_PWM_ON:    cfg_d.left_pwm_on = cfg_wdata_i[ttd_pkg::PWM_W-1:0];
        ttd_pkg::REG_LEFT_QUARTER:   cfg_d.left_quarter_ticks = cfg_wdata_i[ttd_pkg::CNT_W-1:0];
        ttd_pkg::REG_RIGHT_QUARTER:  cfg_d.right_quarter_ticks = cfg_wdata_i[ttd_pkg::CNT_W-1:0];
        ttd_pkg::REG_HALF_TURN:      cfg_d.half_turn_ticks = cfg_wdata_i[ttd_pkg::CNT_W-1:0];
        ttd_pkg::REG_TICKS_PER_DEG:  cfg_d.ticks_per_degree = cfg_wdata_i[ttd_pkg::TPD_W-1:0];
        ttd_pkg::REG_PAUSE:          cfg_d.pause_ticks = cfg_wdata_i[ttd_pkg::CNT_W-1:0];
        ttd_pkg::REG_TICKS_PER_CELL: cfg_d.ticks_per_cell = cfg_wdata_i[ttd_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= ttd_pkg::CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### sv/ttd_front.sv
module ttd_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ttd_pkg::cfg_t        cfg_i,
  input  logic                 push_i,
  output logic                 full_o,
  input  ttd_pkg::in_item_t    in_item_i,
  input  ttd_pkg::q_status_t   q_status_i,
  output logic                 q_wr_o,
  output ttd_pkg::dec_t        q_data_o
);

  logic                        s1_valid_q, s1_valid_d;
  ttd_pkg::front_t             s1_q, s1_d;
  logic                        accept;
  logic                        advance;

  logic [ttd_pkg::ANGLE_W-1:0] pose_r, tgt_r, ccw, cw, ang;
  logic [ttd_pkg::ANGLE_W:0]   diff;
  logic                        left_short;
  logic [ttd_pkg::PROD_W-1:0]  prod;
  logic [ttd_pkg::TICK_W-1:0]  turn_ticks;
  logic [ttd_pkg::DRIVE_W-1:0] drive_ticks;

  assign advance    = s1_valid_q && q_status_i.ready;
  assign full_o     = s1_valid_q && !q_status_i.ready;
  assign accept     = push_i && !full_o;
  assign s1_valid_d = accept || (s1_valid_q && !q_status_i.ready);

  // heading differences and turn class
  always_comb begin
    pose_r = (in_item_i.pose_angle >= ttd_pkg::DEG_FULL) ?
             in_item_i.pose_angle - ttd_pkg::DEG_FULL : in_item_i.pose_angle;
    tgt_r  = (in_item_i.target_heading >= ttd_pkg::DEG_FULL) ?
             in_item_i.target_heading - ttd_pkg::DEG_FULL : in_item_i.target_heading;
    diff   = {1'b0, tgt_r} + {1'b0, ttd_pkg::DEG_FULL} - {1'b0, pose_r};
    ccw    = (diff >= {1'b0, ttd_pkg::DEG_FULL}) ?
             ttd_pkg::ANGLE_W'(diff - {1'b0, ttd_pkg::DEG_FULL}) : diff[ttd_pkg::ANGLE_W-1:0];
    cw     = (ccw == '0) ? '0 : ttd_pkg::DEG_FULL - ccw;
    left_short = ccw < cw;
    ang    = left_short ? ccw : cw;

    s1_d.cmd   = in_item_i.cmd;
    s1_d.zero  = (ccw == '0);
    s1_d.ccw   = ccw;
    s1_d.ang   = ang[ttd_pkg::ANG_W-1:0];
    s1_d.cells = in_item_i.cell_count;
    if (ang >= ttd_pkg::QUARTER_LO && ang <= ttd_pkg::QUARTER_HI) begin
      s1_d.cls  = ttd_pkg::TC_QUARTER;
      s1_d.left = left_short;
    end else if (ang >= ttd_pkg::HALF_LO && ang <= ttd_pkg::HALF_HI) begin
      s1_d.cls  = ttd_pkg::TC_HALF;
      s1_d.left = 1'b1;
    end else begin
      s1_d.cls  = ttd_pkg::TC_SCALED;
      s1_d.left = left_short;
    end
  end

  // turn and drive lengths
  always_comb begin
    prod        = ttd_pkg::PROD_W'(s1_q.ang) * ttd_pkg::PROD_W'(cfg_i.ticks_per_degree);
    drive_ticks = ttd_pkg::DRIVE_W'(s1_q.cells) * ttd_pkg::DRIVE_W'(cfg_i.ticks_per_cell);
    unique case (s1_q.cls)
      ttd_pkg::TC_QUARTER: begin
        turn_ticks = ttd_pkg::TICK_W'(s1_q.left ? cfg_i.left_quarter_ticks
                                                : cfg_i.right_quarter_ticks);
      end
      ttd_pkg::TC_HALF: begin
        turn_ticks = ttd_pkg::TICK_W'(cfg_i.half_turn_ticks);
      end
      default: begin
        turn_ticks = prod[ttd_pkg::PROD_W-1:ttd_pkg::TPD_FRAC];
      end
    endcase
  end

  assign q_wr_o               = advance;
  assign q_data_o.cmd         = s1_q.cmd;
  assign q_data_o.zero        = s1_q.zero;
  assign q_data_o.left        = s1_q.left;
  assign q_data_o.ccw         = s1_q.ccw;
  assign q_data_o.turn_ticks  = turn_ticks;
  assign q_data_o.drive_ticks = drive_ticks;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
  end

endmodule

### sv/ttd_cmd_queue.sv
module ttd_cmd_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_i,
  input  ttd_pkg::dec_t       wr_data_i,
  input  logic                rd_i,
  output ttd_pkg::q_status_t  status_o,
  output ttd_pkg::dec_t       rd_data_o
);

  ttd_pkg::dec_t                   mem_q [ttd_pkg::QUEUE_DEPTH];
  logic [ttd_pkg::QUEUE_PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [ttd_pkg::QUEUE_CNT_W-1:0] cnt_q, cnt_d;
  logic                            do_wr, do_rd;

  assign status_o.ready = cnt_q < ttd_pkg::QUEUE_CNT_W'(ttd_pkg::QUEUE_DEPTH);
  assign status_o.valid = cnt_q != '0;
  assign do_wr          = wr_i && status_o.ready;
  assign do_rd          = rd_i && status_o.valid;
  assign rd_data_o      = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == ttd_pkg::QUEUE_PTR_W'(ttd_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == ttd_pkg::QUEUE_PTR_W'(ttd_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_wr && do_rd) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

### sv/ttd_back.sv
module ttd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ttd_pkg::cfg_t       cfg_i,
  input  ttd_pkg::q_status_t  q_status_i,
  input  ttd_pkg::dec_t       q_data_i,
  output logic                q_rd_o,
  output logic                empty_o,
  input  logic                pop_i,
  output ttd_pkg::result_t    result_o
);

  ttd_pkg::phase_e               phase_q, phase_d;
  logic [ttd_pkg::TICK_W-1:0]    rem_q, rem_d;
  logic [ttd_pkg::DRIVE_W-1:0]   pend_q, pend_d;
  logic [ttd_pkg::PWM_W-1:0]     right_q, right_d, left_q, left_d;
  logic                          dir_q, dir_d;
  logic [ttd_pkg::ANGLE_W-1:0]   ccw_q, ccw_d;
  logic                          rejected, finished;
  logic                          fire;
  ttd_pkg::result_t              res;

  ttd_pkg::result_t              out_mem_q [ttd_pkg::OUT_DEPTH];
  logic [ttd_pkg::OUT_PTR_W-1:0] out_wr_q, out_wr_d, out_rd_q, out_rd_d;
  logic [ttd_pkg::OUT_CNT_W-1:0] out_cnt_q, out_cnt_d;
  logic                          out_pop;

  assign fire    = q_status_i.valid &&
                   (out_cnt_q < ttd_pkg::OUT_CNT_W'(ttd_pkg::OUT_DEPTH));
  assign q_rd_o  = fire;
  assign empty_o = out_cnt_q == '0;
  assign out_pop = pop_i && !empty_o;

  always_comb begin
    phase_d  = phase_q;
    rem_d    = rem_q;
    pend_d   = pend_q;
    right_d  = right_q;
    left_d   = left_q;
    dir_d    = dir_q;
    ccw_d    = ccw_q;
    rejected = 1'b0;
    finished = 1'b0;
    if (fire) begin
      if (q_data_i.cmd == ttd_pkg::CMD_MOVE) begin
        if (phase_q == ttd_pkg::PH_IDLE) begin
          ccw_d  = q_data_i.ccw;
          pend_d = q_data_i.drive_ticks;
          dir_d  = 1'b1;
          if (q_data_i.zero) begin
            right_d = cfg_i.right_pwm_on;
            left_d  = cfg_i.left_pwm_on;
            rem_d   = q_data_i.drive_ticks;
            phase_d = ttd_pkg::PH_DRIVE;
          end else begin
            right_d = q_data_i.left ? cfg_i.right_pwm_on : '0;
            left_d  = q_data_i.left ? '0 : cfg_i.left_pwm_on;
            rem_d   = q_data_i.turn_ticks;
            phase_d = ttd_pkg::PH_TURN;
          end
        end else begin
          rejected = 1'b1;
        end
      end else if (phase_q != ttd_pkg::PH_IDLE) begin
        if (rem_q > ttd_pkg::TICK_W'(1)) begin
          rem_d = rem_q - 1'b1;
        end else begin
          unique case (phase_q)
            ttd_pkg::PH_TURN: begin
              right_d = '0;
              left_d  = '0;
              rem_d   = ttd_pkg::TICK_W'(cfg_i.pause_ticks);
              phase_d = ttd_pkg::PH_PAUSE;
            end
            ttd_pkg::PH_PAUSE: begin
              right_d = cfg_i.right_pwm_on;
              left_d  = cfg_i.left_pwm_on;
              dir_d   = 1'b1;
              rem_d   = pend_q;
              phase_d = ttd_pkg::PH_DRIVE;
            end
            ttd_pkg::PH_DRIVE: begin
              right_d  = '0;
              left_d   = '0;
              rem_d    = '0;
              phase_d  = ttd_pkg::PH_IDLE;
              finished = 1'b1;
            end
            ttd_pkg::PH_IDLE: ;
            default: ;
          endcase
        end
      end
    end
  end

  always_comb begin
    res.pwm_right     = right_d;
    res.pwm_left      = left_d;
    res.drive_forward = dir_d;
    res.phase         = phase_d;
    res.ccw_angle     = ccw_d;
    res.rejected      = rejected;
    res.finished      = finished;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ttd_pkg::PH_IDLE;
      rem_q   <= '0;
      pend_q  <= '0;
      right_q <= '0;
      left_q  <= '0;
      dir_q   <= 1'b0;
      ccw_q   <= '0;
    end else begin
      phase_q <= phase_d;
      rem_q   <= rem_d;
      pend_q  <= pend_d;
      right_q <= right_d;
      left_q  <= left_d;
      dir_q   <= dir_d;
      ccw_q   <= ccw_d;
    end
  end

  // result queue
  always_comb begin
    out_wr_d  = out_wr_q;
    out_rd_d  = out_rd_q;
    out_cnt_d = out_cnt_q;
    if (fire) begin
      out_wr_d = (out_wr_q == ttd_pkg::OUT_PTR_W'(ttd_pkg::OUT_DEPTH - 1)) ?
                 '0 : out_wr_q + 1'b1;
    end
    if (out_pop) begin
      out_rd_d = (out_rd_q == ttd_pkg::OUT_PTR_W'(ttd_pkg::OUT_DEPTH - 1)) ?
                 '0 : out_rd_q + 1'b1;
    end
    if (fire && !out_pop) begin
      out_cnt_d = out_cnt_q + 1'b1;
    end else if (!fire && out_pop) begin
      out_cnt_d = out_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_wr_q  <= '0;
      out_rd_q  <= '0;
      out_cnt_q <= '0;
    end else begin
      out_wr_q  <= out_wr_d;
      out_rd_q  <= out_rd_d;
      out_cnt_q <= out_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_mem_q[out_wr_q] <= res;
    end
  end

  assign result_o = out_mem_q[out_rd_q];

endmodule

### sv/turn_then_drive_sequencer_unit.sv
// flow: an item taken on push is held in the front stage register, then written to
// the command queue; the sequencer step then puts its result in the result queue,
// shown on result ports until popped; each step stalls while its next queue is full
// throughput: one item per cycle while neither queue is full
// reset: asynchronous active low; sequencer idle with motors off, registers at
// their defaults, both queues empty
module turn_then_drive_sequencer_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ttd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ttd_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                            push,
  output logic                            full,
  input  ttd_pkg::in_item_t               in_item_i,
  output logic                            empty,
  input  logic                            pop,
  output ttd_pkg::result_t                result_o
);

  ttd_pkg::cfg_t      cfg;
  ttd_pkg::q_status_t q_status;
  ttd_pkg::dec_t      q_wr_data, q_rd_data;
  logic               q_wr, q_rd;

  ttd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  ttd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .push_i     (push),
    .full_o     (full),
    .in_item_i  (in_item_i),
    .q_status_i (q_status),
    .q_wr_o     (q_wr),
    .q_data_o   (q_wr_data)
  );

  ttd_cmd_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (q_wr),
    .wr_data_i (q_wr_data),
    .rd_i      (q_rd),
    .status_o  (q_status),
    .rd_data_o (q_rd_data)
  );

  ttd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .q_status_i (q_status),
    .q_data_i   (q_rd_data),
    .q_rd_o     (q_rd),
    .empty_o    (empty),
    .pop_i      (pop),
    .result_o   (result_o)
  );

endmodule

### sv/ttd_checker.sv
module ttd_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            empty,
  input  logic                            pop,
  input  ttd_pkg::result_t                result_o
);

  // motors are off whenever the sequencer reports idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.phase == ttd_pkg::PH_IDLE) |->
      (result_o.pwm_right == '0 && result_o.pwm_left == '0))
    else $error("motor running while idle");

  // the drive phase only ends back in idle, never on a rejected command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.finished) |->
      (result_o.phase == ttd_pkg::PH_IDLE && !result_o.rejected))
    else $error("finish flag outside idle");

  // a turn drives one side only and the direction line is set once moving
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.phase == ttd_pkg::PH_TURN) |->
      ((result_o.pwm_right == '0 || result_o.pwm_left == '0) && result_o.drive_forward))
    else $error("both motors on during a turn");

  // a waiting result holds until its transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(result_o)))
    else $error("result changed before transfer");

endmodule

bind turn_then_drive_sequencer_unit ttd_checker u_ttd_checker (.*);
